>>> rtl/core/igu_pkg.sv
// Package for the IOMMU interrupt generator: shared types, operation codes,
// register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package igu_pkg;

    localparam int VECTOR_COUNT = 16;
    localparam int VEC_IDX_W    = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
    localparam logic [4:0] VEC_LIMIT = 5'(VECTOR_COUNT);

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 128;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_RAISE   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_WRITE   = 2'd2,
        OP_CLEAR   = 2'd3
    } igu_op_t;

    typedef enum logic [2:0] {
        REG_WIRE_MODE  = 3'd0,
        REG_PA_SIZE    = 3'd1,
        REG_BYTE_ORDER = 3'd2,
        REG_QUEUE_EN   = 3'd3,
        REG_VECTOR_MAP = 3'd4,
        REG_RCID       = 3'd5,
        REG_MCID       = 3'd6
    } igu_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } igu_state_t;

    localparam int UNIT_MONITOR = 3;

    typedef struct packed {
        logic [63:0] address;
        logic [31:0] payload;
        logic        masked;
    } igu_entry_t;

    typedef struct packed {
        logic        msi_write;
        logic        msi_fault;
        logic [63:0] address;
        logic [31:0] payload;
        logic        byte_order;
        logic [11:0] rcid;
        logic [11:0] mcid;
    } igu_msg_t;

    typedef struct packed {
        logic [5:0]  pa_size;
        logic        byte_order;
        logic [11:0] rcid;
        logic [11:0] mcid;
    } igu_msg_cfg_t;

endpackage

>>> rtl/core/iommu_interrupt_generator_unit.sv
// Interrupt generator top: stream ports, configuration registers, pending
// state and sequencing around the MSI table memory. Uses igu_pkg,
// igu_table_mem and igu_msg.
// The table read is registered at the input transfer; the result is registered
// into the output once the output is free. No new input is taken until then.
// Reset: registers to defaults, pending bits cleared, table reads as zero.
`timescale 1ns / 1ps

module iommu_interrupt_generator_unit
    import igu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operation[1:0], source_unit[3:2], vector_index[7:4], entry_address[71:8],
    // entry_payload[103:72], entry_masked[104], clear_mask[108:105], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // msi_write[0], msi_fault[1], write_address[65:2], write_payload[97:66],
    // write_byte_order[98], write_rcid[110:99], write_mcid[122:111],
    // pending_sources_out[126:123], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic        wire_mode_reg;
    logic [5:0]  pa_size_reg;
    logic        byte_order_reg;
    logic [2:0]  queue_en_reg;
    logic [15:0] vector_map_reg;
    logic [11:0] rcid_reg;
    logic [11:0] mcid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wire_mode_reg  <= 1'b0;
            pa_size_reg    <= 6'd56;
            byte_order_reg <= 1'b0;
            queue_en_reg   <= 3'd0;
            vector_map_reg <= 16'd0;
            rcid_reg       <= 12'd0;
            mcid_reg       <= 12'd0;
        end else if (cfg_wr_en) begin
            case (igu_reg_t'(cfg_index))
                REG_WIRE_MODE:  wire_mode_reg  <= cfg_wdata[0];
                REG_PA_SIZE:    pa_size_reg    <= cfg_wdata[5:0];
                REG_BYTE_ORDER: byte_order_reg <= cfg_wdata[0];
                REG_QUEUE_EN:   queue_en_reg   <= cfg_wdata[2:0];
                REG_VECTOR_MAP: vector_map_reg <= cfg_wdata;
                REG_RCID:       rcid_reg       <= cfg_wdata[11:0];
                REG_MCID:       mcid_reg       <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    igu_state_t state_reg, state_next;

    igu_op_t     in_op;
    logic [1:0]  in_unit;
    logic [3:0]  in_vec;
    logic [3:0]  rd_vec;
    logic        in_xfer;

    assign in_op   = igu_op_t'(s_tdata[1:0]);
    assign in_unit = s_tdata[3:2];
    assign in_vec  = s_tdata[7:4];
    assign rd_vec  = (in_op == OP_RAISE) ? vector_map_reg[{in_unit, 2'b00} +: 4] : in_vec;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    igu_op_t     op_reg;
    logic [1:0]  unit_reg;
    logic [3:0]  vec_reg;
    igu_entry_t  wr_entry_reg;
    logic [3:0]  clear_mask_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg                <= in_op;
            unit_reg              <= in_unit;
            vec_reg               <= rd_vec;
            wr_entry_reg.address  <= s_tdata[71:8];
            wr_entry_reg.payload  <= s_tdata[103:72];
            wr_entry_reg.masked   <= s_tdata[104];
            clear_mask_reg        <= s_tdata[108:105];
        end
    end

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;
    logic                  commit;

    logic [3:0]              src_pend_reg, src_pend_next;
    logic [VECTOR_COUNT-1:0] vec_pend_reg, vec_pend_next;

    logic [VEC_IDX_W-1:0] vec_idx;
    logic                 vec_ok;
    logic                 unit_en;
    logic                 raise_go;
    logic                 send;
    logic                 mem_wr_en;
    igu_entry_t           rd_entry;
    igu_msg_cfg_t         msg_cfg;
    igu_msg_t             msg;

    assign vec_idx = vec_reg[VEC_IDX_W-1:0];
    assign vec_ok  = (5'(vec_reg) < VEC_LIMIT);
    assign unit_en = (unit_reg == 2'(UNIT_MONITOR)) || queue_en_reg[unit_reg];
    assign raise_go = !src_pend_reg[unit_reg] && unit_en;

    always_comb begin
        state_next    = state_reg;
        commit        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (!m_valid_reg || m_tready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        send          = 1'b0;
        src_pend_next = src_pend_reg;
        vec_pend_next = vec_pend_reg;
        case (op_reg)
            OP_RAISE: begin
                if (raise_go) begin
                    src_pend_next[unit_reg] = 1'b1;
                    if (!wire_mode_reg && vec_ok) begin
                        if (rd_entry.masked) begin
                            vec_pend_next[vec_idx] = 1'b1;
                        end else begin
                            send = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (vec_ok && vec_pend_reg[vec_idx]) begin
                    send = 1'b1;
                    vec_pend_next[vec_idx] = 1'b0;
                end
            end
            OP_CLEAR: begin
                src_pend_next = src_pend_reg & ~clear_mask_reg;
            end
            default: ;
        endcase
    end

    assign mem_wr_en = commit && (op_reg == OP_WRITE) && vec_ok;

    igu_table_mem u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr_en),
        .wr_addr  (vec_idx),
        .wr_entry (wr_entry_reg),
        .rd_en    (in_xfer),
        .rd_addr  (rd_vec[VEC_IDX_W-1:0]),
        .rd_entry (rd_entry)
    );

    assign msg_cfg.pa_size    = pa_size_reg;
    assign msg_cfg.byte_order = byte_order_reg;
    assign msg_cfg.rcid       = rcid_reg;
    assign msg_cfg.mcid       = mcid_reg;

    igu_msg u_msg (
        .send  (send),
        .entry (rd_entry),
        .cfg   (msg_cfg),
        .msg   (msg)
    );

    assign m_data_next = {1'b0, src_pend_next, msg.mcid, msg.rcid, msg.byte_order,
                          msg.payload, msg.address, msg.msi_fault, msg.msi_write};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            src_pend_reg <= '0;
            vec_pend_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg  <= 1'b1;
                src_pend_reg <= src_pend_next;
                vec_pend_reg <= vec_pend_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/core/igu_table_mem.sv
// MSI table memory: one write port, one registered read port.
// Per-entry valid flags make unwritten entries read as zero. Uses igu_pkg.
`timescale 1ns / 1ps

module igu_table_mem
    import igu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [VEC_IDX_W-1:0] wr_addr,
    input  igu_entry_t           wr_entry,
    input  logic                 rd_en,
    input  logic [VEC_IDX_W-1:0] rd_addr,
    output igu_entry_t           rd_entry
);

    igu_entry_t mem [VECTOR_COUNT];
    logic [VECTOR_COUNT-1:0] valid_reg;
    igu_entry_t rd_data_reg;
    logic       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/igu_msg.sv
// MSI message builder: address range check against pa_size and result
// formatting for a write or a write fault. Uses igu_pkg.
`timescale 1ns / 1ps

module igu_msg
    import igu_pkg::*;
(
    input  logic         send,
    input  igu_entry_t   entry,
    input  igu_msg_cfg_t cfg,
    output igu_msg_t     msg
);

    logic [63:0] high_bits;
    logic        fault;

    assign high_bits = entry.address >> cfg.pa_size;
    assign fault     = (high_bits != 64'd0);

    always_comb begin
        msg = '0;
        if (send) begin
            msg.address = entry.address;
            if (fault) begin
                msg.msi_fault = 1'b1;
            end else begin
                msg.msi_write  = 1'b1;
                msg.payload    = entry.payload;
                msg.byte_order = cfg.byte_order;
                msg.rcid       = cfg.rcid;
                msg.mcid       = cfg.mcid;
            end
        end
    end

endmodule

>>> rtl/core/igu_checker.sv
// Port-level checker for the interrupt generator top, with its bind.
// Uses igu_pkg; attaches to iommu_interrupt_generator_unit.
`timescale 1ns / 1ps

module igu_checker
    import igu_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_write_xor_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("msi write and msi fault both set");

    a_quiet_no_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0] && !m_tdata[1]) |-> (m_tdata[122:2] == '0))
        else $error("message fields nonzero without a message");

    a_fault_attrs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[122:66] == '0))
        else $error("fault result carries write attributes");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind iommu_interrupt_generator_unit igu_checker u_igu_checker (.*);

>>> tb/sv/tb.sv
// Testbench for iommu_interrupt_generator_unit: stream driver and monitor with a
// self-checking interrupt/MSI predictor, directed then random traffic.
// Depends on igu_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;
    import igu_pkg::*;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_LEN    = 300;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        igu_op_t     op;
        logic [1:0]  unit;
        logic [3:0]  vec;
        logic [63:0] addr;
        logic [31:0] data;
        logic        masked;
        logic [3:0]  clr;
    } irq_item_t;

    typedef struct packed {
        logic        msi_write;
        logic        msi_fault;
        logic [63:0] address;
        logic [31:0] payload;
        logic        byte_order;
        logic [11:0] rcid;
        logic [11:0] mcid;
        logic [3:0]  pending;
    } irq_result_t;

    typedef struct {
        logic        wire_mode;
        logic [5:0]  pa_size;
        logic        byte_order;
        logic [2:0]  queue_en;
        logic [15:0] vec_map;
        logic [11:0] rcid;
        logic [11:0] mcid;
    } irq_cfg_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    iommu_interrupt_generator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the block's registers and state
    irq_cfg_t    cfg_now;
    logic [3:0]  src_pend;
    logic [63:0] tbl_addr [VECTOR_COUNT];
    logic [31:0] tbl_data [VECTOR_COUNT];
    logic        tbl_mask [VECTOR_COUNT];
    logic        vec_pend [VECTOR_COUNT];

    irq_item_t   pend_q[$];
    irq_result_t msi_expected_q[$];

    int idle_pct_s = 0;
    int idle_pct_m = 0;
    int hold_req   = 0;
    int n_err      = 0;
    int n_items    = 0;
    int n_msi      = 0;
    int n_fault    = 0;
    int n_cfg      = 0;
    int cycles     = 0;

    function automatic irq_result_t form_message(logic [3:0] v);
        irq_result_t m = '0;
        if ((tbl_addr[v] >> cfg_now.pa_size) != 64'd0) begin
            m.msi_fault = 1'b1;
            m.address   = tbl_addr[v];
        end else begin
            m.msi_write  = 1'b1;
            m.address    = tbl_addr[v];
            m.payload    = tbl_data[v];
            m.byte_order = cfg_now.byte_order;
            m.rcid       = cfg_now.rcid;
            m.mcid       = cfg_now.mcid;
        end
        return m;
    endfunction

    function automatic irq_result_t resolve_interrupt(irq_item_t it);
        irq_result_t r = '0;
        logic [3:0] v;
        logic enabled;
        case (it.op)
            OP_RAISE: begin
                v = cfg_now.vec_map[4*it.unit +: 4];
                enabled = (it.unit == UNIT_MONITOR) || cfg_now.queue_en[it.unit];
                if (!src_pend[it.unit] && enabled) begin
                    src_pend[it.unit] = 1'b1;
                    if (!cfg_now.wire_mode) begin
                        if (tbl_mask[v])
                            vec_pend[v] = 1'b1;
                        else
                            r = form_message(v);
                    end
                end
            end
            OP_RELEASE: begin
                if (vec_pend[it.vec]) begin
                    r = form_message(it.vec);
                    vec_pend[it.vec] = 1'b0;
                end
            end
            OP_WRITE: begin
                tbl_addr[it.vec] = it.addr;
                tbl_data[it.vec] = it.data;
                tbl_mask[it.vec] = it.masked;
            end
            default: begin
                src_pend = src_pend & ~it.clr;
            end
        endcase
        r.pending = src_pend;
        return r;
    endfunction

    function automatic irq_item_t mk(igu_op_t op, logic [1:0] unit, logic [3:0] vec,
                                     logic [63:0] addr, logic [31:0] data, logic masked,
                                     logic [3:0] clr);
        irq_item_t it;
        it.op = op; it.unit = unit; it.vec = vec; it.addr = addr;
        it.data = data; it.masked = masked; it.clr = clr;
        return it;
    endfunction

    function automatic irq_item_t make_random_item();
        irq_item_t it;
        int r = $urandom_range(99);
        int a = $urandom_range(99);
        it = mk(OP_RAISE, 2'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom,
                1'($urandom_range(9) < 3), 4'($urandom));
        if (r < 35)
            it.op = OP_RAISE;
        else if (r < 60)
            it.op = OP_RELEASE;
        else if (r < 85)
            it.op = OP_WRITE;
        else
            it.op = OP_CLEAR;
        if (it.op == OP_RELEASE && $urandom_range(9) < 6)
            it.vec = cfg_now.vec_map[4*$urandom_range(3) +: 4];
        if (a < 60)
            it.addr = it.addr & ((64'd1 << cfg_now.pa_size) - 64'd1);
        else if (a < 70)
            it.addr = (64'd1 << cfg_now.pa_size) - 64'd1;
        else if (a < 80)
            it.addr = 64'd1 << cfg_now.pa_size;
        return it;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_err++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        irq_item_t cur;
        logic [IN_DATA_W-1:0] d;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cur.op     = igu_op_t'(s_tdata[1:0]);
                cur.unit   = s_tdata[3:2];
                cur.vec    = s_tdata[7:4];
                cur.addr   = s_tdata[71:8];
                cur.data   = s_tdata[103:72];
                cur.masked = s_tdata[104];
                cur.clr    = s_tdata[108:105];
                msi_expected_q.push_back(resolve_interrupt(cur));
                n_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct_s) begin
                    cur = pend_q.pop_front();
                    d = '0;
                    d[1:0]     = cur.op;
                    d[3:2]     = cur.unit;
                    d[7:4]     = cur.vec;
                    d[71:8]    = cur.addr;
                    d[103:72]  = cur.data;
                    d[104]     = cur.masked;
                    d[108:105] = cur.clr;
                    s_tdata  <= d;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        irq_result_t got, want;
        int hold_seen;
        int hold_left;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.msi_write  = m_tdata[0];
                got.msi_fault  = m_tdata[1];
                got.address    = m_tdata[65:2];
                got.payload    = m_tdata[97:66];
                got.byte_order = m_tdata[98];
                got.rcid       = m_tdata[110:99];
                got.mcid       = m_tdata[122:111];
                got.pending    = m_tdata[126:123];
                if (msi_expected_q.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    n_err++;
                end else begin
                    want = msi_expected_q.pop_front();
                    check_field("msi_write", want.msi_write, got.msi_write);
                    check_field("msi_fault", want.msi_fault, got.msi_fault);
                    check_field("write_address", want.address, got.address);
                    check_field("write_payload", want.payload, got.payload);
                    check_field("write_byte_order", want.byte_order, got.byte_order);
                    check_field("write_rcid", want.rcid, got.rcid);
                    check_field("write_mcid", want.mcid, got.mcid);
                    check_field("pending_sources_out", want.pending, got.pending);
                    n_msi   += got.msi_write;
                    n_fault += got.msi_fault;
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct_m);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic put_reg(igu_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_config(irq_cfg_t c);
        put_reg(REG_WIRE_MODE, CFG_DATA_W'(c.wire_mode));
        put_reg(REG_PA_SIZE, CFG_DATA_W'(c.pa_size));
        put_reg(REG_BYTE_ORDER, CFG_DATA_W'(c.byte_order));
        put_reg(REG_QUEUE_EN, CFG_DATA_W'(c.queue_en));
        put_reg(REG_VECTOR_MAP, c.vec_map);
        put_reg(REG_RCID, CFG_DATA_W'(c.rcid));
        put_reg(REG_MCID, CFG_DATA_W'(c.mcid));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
        n_cfg++;
    endtask

    // sampled mid-cycle so the driver's and monitor's updates have settled
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || msi_expected_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        irq_cfg_t c;
        cfg_now  = '{1'b0, 6'd56, 1'b0, 3'd0, 16'h0, 12'h0, 12'h0};
        src_pend = '0;
        for (int i = 0; i < VECTOR_COUNT; i++) begin
            tbl_addr[i] = '0;
            tbl_data[i] = '0;
            tbl_mask[i] = 1'b0;
            vec_pend[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: MSI mode, 40-bit physical space
        apply_config('{1'b0, 6'd40, 1'b1, 3'd7, 16'h3210, 12'hFFF, 12'hA5A});
        pend_q.push_back(mk(OP_WRITE, 0, 0, 64'h0000_00FF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 2, 64'h0000_0100_0000_0000, 32'hDEAD_BEEF, 1, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 3, 64'h0, 32'h1234_5678, 0, 0));
        pend_q.push_back(mk(OP_RAISE, 0, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_RAISE, 0, 0, 0, 0, 0, 0));   // already pending
        pend_q.push_back(mk(OP_RAISE, 1, 0, 0, 0, 0, 0));   // address fault
        pend_q.push_back(mk(OP_RAISE, 2, 0, 0, 0, 0, 0));   // masked entry
        pend_q.push_back(mk(OP_RAISE, 3, 0, 0, 0, 0, 0));   // monitor, no enable
        pend_q.push_back(mk(OP_RELEASE, 0, 2, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_RELEASE, 0, 2, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_RELEASE, 0, 15, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 4'hF));
        pend_q.push_back(mk(OP_WRITE, 0, 15, 64'h8000_0000_0000_0000, 32'h8000_0001, 0, 0));
        pend_q.push_back(mk(OP_WRITE, 0, 2, 64'h0000_00AB_CDEF_0123, 32'h0F0F_0F0F, 1, 0));
        pend_q.push_back(mk(OP_RAISE, 2, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 4'h0));
        pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 4'h5));
        wait_drained();

        // directed: wired mode, queue enables off
        apply_config('{1'b1, 6'd63, 1'b0, 3'd0, 16'hF2F2, 12'h000, 12'h5A5});
        pend_q.push_back(mk(OP_RAISE, 0, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_RAISE, 3, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_RELEASE, 0, 2, 0, 0, 0, 0));
        pend_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 4'hF));
        wait_drained();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            c.wire_mode  = ($urandom_range(3) == 0);
            c.pa_size    = 6'($urandom_range(56, 1));
            c.byte_order = 1'($urandom);
            c.queue_en   = 3'($urandom);
            c.vec_map    = 16'($urandom);
            c.rcid       = 12'($urandom);
            c.mcid       = 12'($urandom);
            case (ph)
                0: c.wire_mode = 1'b0;
                1: c = '{1'b0, 6'd1, 1'b0, 3'd0, 16'h0000, 12'h000, 12'h000};
                2: c = '{1'b0, 6'd63, 1'b1, 3'd7, 16'hFFFF, 12'hFFF, 12'hFFF};
                4: c.wire_mode = 1'b1;
                5: c.pa_size = 6'd0;
                6: c.pa_size = 6'd56;
                default: ;
            endcase
            apply_config(c);
            case (ph % 4)
                0: begin idle_pct_s = 0;  idle_pct_m = 0;  end
                1: begin idle_pct_s = 55; idle_pct_m = 0;  end
                2: begin idle_pct_s = 0;  idle_pct_m = 55; end
                default: begin idle_pct_s = 22; idle_pct_m = 22; end
            endcase
            // back-pressure: receiver holds off while the sender keeps going
            if (ph == 0)
                hold_req++;
            for (int i = 0; i < PHASE_ITEMS / 2; i++)
                pend_q.push_back(make_random_item());
            wait_drained();
            for (int i = 0; i < PHASE_ITEMS - PHASE_ITEMS / 2; i++)
                pend_q.push_back(make_random_item());
            wait_drained();
        end

        idle_pct_s = 0;
        idle_pct_m = 0;
        repeat (10) @(posedge aclk);
        $display("tb: %0d transfers over %0d register settings, %0d MSI writes, %0d MSI faults",
                 n_items, n_cfg, n_msi, n_fault);
        if (n_err == 0 && msi_expected_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
